@@ rtl/mpa_pkg.sv @@
package mpa_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_IN_WIDTH    = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_WINDOW_SIZE = 3'd2;
  localparam logic [2:0] REG_STEP        = 3'd3;
  localparam logic [2:0] REG_PAD_TOTAL   = 3'd4;
  localparam logic [2:0] REG_RECORD      = 3'd5;
  localparam int unsigned REG_COUNT      = 6;
  localparam int unsigned CFG_ADDR_W     = 5;

  // register reset values
  localparam logic [8:0] RST_IN_WIDTH    = 9'd8;
  localparam logic [8:0] RST_IN_HEIGHT   = 9'd8;
  localparam logic [3:0] RST_WINDOW_SIZE = 4'd2;
  localparam logic [3:0] RST_STEP        = 4'd2;
  localparam logic [3:0] RST_PAD_TOTAL   = 4'd0;
  localparam logic       RST_RECORD      = 1'b1;

  // results per pixel are capped
  localparam int unsigned MAX_RESULTS = 64;

  typedef struct packed {
    logic [8:0] in_width;
    logic [8:0] in_height;
    logic [3:0] window_size;
    logic [3:0] step;
    logic [3:0] pad_total;
    logic       record_index;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_SET1,
    ST_SET2,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic row_step;
    logic col_step;
    logic set1;
    logic set2;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic first_col;
    logic row_hit;
    logic col_hit;
    logic have_win;
    logic win_empty;
    logic scan_last;
    logic out_free;
    logic run_last;
  } sts_t;

endpackage

@@ rtl/mpa_if.sv @@
interface mpa_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mpa_out_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pooled_value;
  logic [15:0]            max_position;
  logic                   window_empty;
  logic [7:0]             out_row;
  logic [7:0]             out_col;
  logic                   last_of_run;
  logic                   plane_done;

  modport source (output valid, output pooled_value, output max_position,
                  output window_empty, output out_row, output out_col,
                  output last_of_run, output plane_done, input ready);
  modport sink (input valid, input pooled_value, input max_position,
                input window_empty, input out_row, input out_col,
                input last_of_run, input plane_done, output ready);
endinterface

@@ rtl/mpa_cfg.sv @@
module mpa_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpa_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output mpa_pkg::cfg_t                       cfg,
  output logic                                restart
);

  mpa_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [2:0]    idx;

  assign idx     = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign restart = wr_en && (32'(idx) < mpa_pkg::REG_COUNT);
  assign cfg     = cfg_r;

  // write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_width     <= mpa_pkg::RST_IN_WIDTH;
      cfg_r.in_height    <= mpa_pkg::RST_IN_HEIGHT;
      cfg_r.window_size  <= mpa_pkg::RST_WINDOW_SIZE;
      cfg_r.step         <= mpa_pkg::RST_STEP;
      cfg_r.pad_total    <= mpa_pkg::RST_PAD_TOTAL;
      cfg_r.record_index <= mpa_pkg::RST_RECORD;
    end else if (wr_en) begin
      unique case (idx)
        mpa_pkg::REG_IN_WIDTH:    cfg_r.in_width     <= pwdata[8:0];
        mpa_pkg::REG_IN_HEIGHT:   cfg_r.in_height    <= pwdata[8:0];
        mpa_pkg::REG_WINDOW_SIZE: cfg_r.window_size  <= pwdata[3:0];
        mpa_pkg::REG_STEP:        cfg_r.step         <= pwdata[3:0];
        mpa_pkg::REG_PAD_TOTAL:   cfg_r.pad_total    <= pwdata[3:0];
        mpa_pkg::REG_RECORD:      cfg_r.record_index <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      mpa_pkg::REG_IN_WIDTH:    prdata = 32'(cfg_r.in_width);
      mpa_pkg::REG_IN_HEIGHT:   prdata = 32'(cfg_r.in_height);
      mpa_pkg::REG_WINDOW_SIZE: prdata = 32'(cfg_r.window_size);
      mpa_pkg::REG_STEP:        prdata = 32'(cfg_r.step);
      mpa_pkg::REG_PAD_TOTAL:   prdata = 32'(cfg_r.pad_total);
      mpa_pkg::REG_RECORD:      prdata = 32'(cfg_r.record_index);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/mpa_ctrl.sv @@
module mpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mpa_pkg::sts_t sts,
  output mpa_pkg::cmd_t cmd
);

  mpa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mpa_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sts.first_col ? mpa_pkg::ST_ROW : mpa_pkg::ST_COL;
      end
      mpa_pkg::ST_ROW: begin
        if (!sts.row_hit) state_nxt = mpa_pkg::ST_COL;
      end
      mpa_pkg::ST_COL: begin
        if (!sts.col_hit) state_nxt = sts.have_win ? mpa_pkg::ST_SET1 : mpa_pkg::ST_IDLE;
      end
      mpa_pkg::ST_SET1: state_nxt = mpa_pkg::ST_SET2;
      mpa_pkg::ST_SET2: state_nxt = sts.win_empty ? mpa_pkg::ST_EMIT : mpa_pkg::ST_SCAN;
      mpa_pkg::ST_SCAN: begin
        if (sts.scan_last) state_nxt = mpa_pkg::ST_DRAIN;
      end
      mpa_pkg::ST_DRAIN: state_nxt = mpa_pkg::ST_EMIT;
      mpa_pkg::ST_EMIT: begin
        if (sts.out_free) state_nxt = sts.run_last ? mpa_pkg::ST_IDLE : mpa_pkg::ST_SET1;
      end
      default: state_nxt = mpa_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready     = (state_r == mpa_pkg::ST_IDLE);
    cmd.accept   = (state_r == mpa_pkg::ST_IDLE) && in_valid;
    cmd.row_step = (state_r == mpa_pkg::ST_ROW) && sts.row_hit;
    cmd.col_step = (state_r == mpa_pkg::ST_COL) && sts.col_hit;
    cmd.set1     = (state_r == mpa_pkg::ST_SET1);
    cmd.set2     = (state_r == mpa_pkg::ST_SET2);
    cmd.scan     = (state_r == mpa_pkg::ST_SCAN);
    cmd.emit     = (state_r == mpa_pkg::ST_EMIT) && sts.out_free;
  end

endmodule

@@ rtl/mpa_dp.sv @@
module mpa_dp #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mpa_pkg::cfg_t          cfg,
  input  logic                   restart,
  input  mpa_pkg::cmd_t          cmd,
  output mpa_pkg::sts_t          sts,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_pooled_value,
  output logic [15:0]            out_max_position,
  output logic                   out_window_empty,
  output logic [7:0]             out_out_row,
  output logic [7:0]             out_out_col,
  output logic                   out_last_of_run,
  output logic                   out_plane_done
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH  = MAX_WINDOW * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic win_exists(input logic [8:0] k, input logic signed [11:0] kt,
                                      input logic signed [11:0] diff, input logic [3:0] t);
    win_exists = ((kt <= diff) && !k[8]) ||
                 ((k == 9'd0) && ((diff + $signed({8'b0, t})) > 12'sd0));
  endfunction

  function automatic logic signed [11:0] clamp_trig(input logic signed [11:0] v,
                                                     input logic signed [11:0] lim);
    clamp_trig = (v < 12'sd0) ? 12'sd0 : ((v > lim) ? lim : v);
  endfunction

  // line buffer
  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // clamped configuration
  logic [8:0]         w_c, h_c;
  logic [3:0]         s_c, t_c;
  logic [2:0]         half_c;
  logic signed [11:0] e_c, diffw_c, diffh_c, wm1_c, hm1_c, half_s, s_s, t_s;

  always_comb begin
    w_c = (cfg.in_width == 9'd0) ? 9'd1 :
          ((int'(cfg.in_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.in_width);
    h_c = (cfg.in_height == 9'd0) ? 9'd1 :
          ((int'(cfg.in_height) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cfg.in_height);
    s_c = (cfg.window_size == 4'd0) ? 4'd1 :
          ((int'(cfg.window_size) > MAX_WINDOW) ? 4'(MAX_WINDOW) : cfg.window_size);
    t_c = (cfg.step == 4'd0) ? 4'd1 : cfg.step;
    half_c  = cfg.pad_total[3:1];
    half_s  = $signed({9'b0, half_c});
    s_s     = $signed({8'b0, s_c});
    t_s     = $signed({8'b0, t_c});
    e_c     = s_s - 12'sd1 - half_s;
    diffw_c = $signed({3'b0, w_c}) + $signed({8'b0, cfg.pad_total}) - s_s;
    diffh_c = $signed({3'b0, h_c}) + $signed({8'b0, cfg.pad_total}) - s_s;
    wm1_c   = $signed({3'b0, w_c}) - 12'sd1;
    hm1_c   = $signed({3'b0, h_c}) - 12'sd1;
  end

  // pixel position
  logic [8:0]        r_r, c_r, pix_r_r, pix_c_r;
  logic [SLOT_W-1:0] slot_r, pix_slot_r;

  // window trackers and per-pixel ranges
  logic [8:0]         kr_r, kc_r, kr_base_r, kc_base_r, kr_n_r, kc_n_r;
  logic signed [11:0] krt_r, kct_r, krt_base_r, kct_base_r;
  logic [8:0]         kr_start, kc_start;
  logic signed [11:0] krt_start, kct_start;
  logic               ex_r, ex_c, hit_r, hit_c;

  // emission cursors
  logic [8:0]         a_r, b_r, cur_i_r, cur_j_r;
  logic signed [11:0] cur_it_r, cur_jt_r;
  logic [6:0]         n_r;
  logic               a_last, b_last, run_last;

  // window setup and scan
  logic signed [11:0] r0, c0, rend, cend;
  logic [8:0]         rs_r, cs_r, sr_r, sc_r;
  logic               empty_r;
  logic [SLOT_W-1:0]  sslot_r;
  logic [17:0]        rowbase_r;
  logic [5:0]         d6, ps6, slot6;
  logic               scan_last;

  // read pipe and running maximum
  logic                   rd_v_r;
  logic [SAMPLE_BITS-1:0] rd_data_r, best_r;
  logic [17:0]            rd_pos_r, bpos_r;
  logic                   found_r;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;

  // output register
  logic out_valid_r, out_free;

  always_comb begin
    ex_r  = win_exists(kr_r, krt_r, diffh_c, t_c);
    ex_c  = win_exists(kc_r, kct_r, diffw_c, t_c);
    hit_r = ex_r && (clamp_trig(krt_r + e_c, hm1_c) == $signed({3'b0, pix_r_r}));
    hit_c = ex_c && (clamp_trig(kct_r + e_c, wm1_c) == $signed({3'b0, pix_c_r}));

    if (c_r == 9'd0) begin
      kr_start  = (r_r == 9'd0) ? 9'd0 : kr_r;
      krt_start = (r_r == 9'd0) ? 12'sd0 : krt_r;
      kc_start  = 9'd0;
      kct_start = 12'sd0;
    end else begin
      kr_start  = kr_base_r;
      krt_start = krt_base_r;
      kc_start  = kc_r;
      kct_start = kct_r;
    end

    a_last   = (a_r == kr_n_r - 9'd1);
    b_last   = (b_r == kc_n_r - 9'd1);
    run_last = (n_r == 7'(mpa_pkg::MAX_RESULTS - 1)) || (a_last && b_last);

    r0   = cur_it_r - half_s;
    c0   = cur_jt_r - half_s;
    rend = r0 + s_s - 12'sd1;
    cend = c0 + s_s - 12'sd1;

    d6    = 6'(pix_r_r - rs_r);
    ps6   = 6'(pix_slot_r);
    slot6 = (ps6 >= d6) ? (ps6 - d6) : (ps6 + 6'(MAX_WINDOW) - d6);

    scan_last = (sc_r == pix_c_r) && (sr_r == pix_r_r);
    wr_addr   = ADDR_W'(slot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_r);
    rd_addr   = ADDR_W'(sslot_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sc_r);
    out_free  = !out_valid_r || out_ready;
  end

  // status
  always_comb begin
    sts.first_col = (c_r == 9'd0);
    sts.row_hit   = hit_r;
    sts.col_hit   = hit_c;
    sts.have_win  = (kr_n_r != 9'd0) && (kc_n_r != 9'd0);
    sts.win_empty = empty_r;
    sts.scan_last = scan_last;
    sts.out_free  = out_free;
    sts.run_last  = run_last;
  end

  // advance the raster position
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      r_r    <= 9'd0;
      c_r    <= 9'd0;
      slot_r <= '0;
    end else if (cmd.accept) begin
      if (c_r + 9'd1 >= w_c) begin
        c_r <= 9'd0;
        if (r_r + 9'd1 >= h_c) begin
          r_r    <= 9'd0;
          slot_r <= '0;
        end else begin
          r_r    <= r_r + 9'd1;
          slot_r <= (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        end
      end else begin
        c_r <= c_r + 9'd1;
      end
    end
  end

  // trackers, ranges and cursors
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r_r    <= r_r;
      pix_c_r    <= c_r;
      pix_slot_r <= slot_r;
      // hold the row tracker past this row's windows until the next row starts
      if (c_r == 9'd0) begin
        kr_r  <= kr_start;
        krt_r <= krt_start;
      end
      kc_r       <= kc_start;
      kct_r      <= kct_start;
      kr_base_r  <= kr_start;
      krt_base_r <= krt_start;
      kc_base_r  <= kc_start;
      kct_base_r <= kct_start;
      if (c_r == 9'd0) kr_n_r <= 9'd0;
      kc_n_r     <= 9'd0;
      a_r        <= 9'd0;
      b_r        <= 9'd0;
      n_r        <= 7'd0;
      cur_i_r    <= kr_start;
      cur_it_r   <= krt_start;
      cur_j_r    <= kc_start;
      cur_jt_r   <= kct_start;
    end
    if (cmd.row_step) begin
      kr_r   <= kr_r + 9'd1;
      krt_r  <= krt_r + t_s;
      kr_n_r <= kr_n_r + 9'd1;
    end
    if (cmd.col_step) begin
      kc_r   <= kc_r + 9'd1;
      kct_r  <= kct_r + t_s;
      kc_n_r <= kc_n_r + 9'd1;
    end
    if (cmd.emit) begin
      n_r <= n_r + 7'd1;
      if (b_last) begin
        b_r      <= 9'd0;
        a_r      <= a_r + 9'd1;
        cur_i_r  <= cur_i_r + 9'd1;
        cur_it_r <= cur_it_r + t_s;
        cur_j_r  <= kc_base_r;
        cur_jt_r <= kct_base_r;
      end else begin
        b_r      <= b_r + 9'd1;
        cur_j_r  <= cur_j_r + 9'd1;
        cur_jt_r <= cur_jt_r + t_s;
      end
    end
  end

  // set up a window and walk its in-image pixels
  always_ff @(posedge clk) begin
    if (cmd.set1) begin
      empty_r <= (rend < 12'sd0) || (r0 > hm1_c) || (cend < 12'sd0) || (c0 > wm1_c);
      rs_r    <= (r0 < 12'sd0) ? 9'd0 : r0[8:0];
      cs_r    <= (c0 < 12'sd0) ? 9'd0 : c0[8:0];
    end
    if (cmd.set2) begin
      sr_r      <= rs_r;
      sc_r      <= cs_r;
      sslot_r   <= SLOT_W'(slot6);
      rowbase_r <= 18'(rs_r) * 18'(w_c);
    end
    if (cmd.scan) begin
      rd_pos_r <= rowbase_r + 18'(sc_r);
      if (sc_r == pix_c_r) begin
        sc_r      <= cs_r;
        sr_r      <= sr_r + 9'd1;
        sslot_r   <= (sslot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : sslot_r + SLOT_W'(1);
        rowbase_r <= rowbase_r + 18'(w_c);
      end else begin
        sc_r <= sc_r + 9'd1;
      end
    end
  end

  // line buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.accept) mem[wr_addr] <= in_sample;
    if (cmd.scan) rd_data_r <= mem[rd_addr];
  end

  // keep the first maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan;
    end
    if (cmd.set1) begin
      found_r <= 1'b0;
    end else if (rd_v_r) begin
      if (!found_r || ($signed(rd_data_r) > $signed(best_r))) begin
        best_r  <= rd_data_r;
        bpos_r  <= rd_pos_r;
        found_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_pooled_value <= found_r ? best_r : SMIN;
      out_max_position <= !cfg.record_index ? 16'd0 :
                          (!found_r ? 16'hFFFF : bpos_r[15:0]);
      out_window_empty <= !found_r;
      out_out_row      <= cur_i_r[7:0];
      out_out_col      <= cur_j_r[7:0];
      out_last_of_run  <= run_last;
      out_plane_done   <= a_last && !ex_r && b_last && !ex_c;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/max_pool_2d_argmax.sv @@
// Channel  Dir  Handshake        Payload
// in_ch    in   valid/ready      sample
// out_ch   out  valid/ready      pooled_value, max_position, window_empty,
//                                out_row, out_col, last_of_run, plane_done
// cfg_*    in   APB, pready=1    six registers at byte address 4*index
//
// A pixel passes through accept and the column tracker, with a tracker step per column window ending
// at its column; at a row start the row tracker comes first, with a step per row window ending there.
// Each window it closes then takes the setup states SET1 and SET2 and an emit; a non-empty one also takes
// one line-buffer read per in-image pixel (single read port) and a drain.
// Reset is synchronous; the line buffer needs no clearing pass.
// A stalled result holds in the output register; only the next emit waits for it.
module max_pool_2d_argmax #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  mpa_in_if.sink                             in_ch,
  mpa_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [mpa_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  mpa_pkg::cfg_t cfg;
  mpa_pkg::cmd_t cmd;
  mpa_pkg::sts_t sts;
  logic          restart;

  assign cfg_pready = 1'b1;

  mpa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .restart (restart)
  );

  mpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpa_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .restart          (restart),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_ch.sample),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_pooled_value (out_ch.pooled_value),
    .out_max_position (out_ch.max_position),
    .out_window_empty (out_ch.window_empty),
    .out_out_row      (out_ch.out_row),
    .out_out_col      (out_ch.out_col),
    .out_last_of_run  (out_ch.last_of_run),
    .out_plane_done   (out_ch.plane_done)
  );

  // a pixel is never followed by another in the next cycle
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken on consecutive cycles");

  // the final window of a plane closes the run of its pixel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.plane_done) |-> out_ch.last_of_run)
    else $error("plane done without last of run");

  // an empty window reports the most negative value
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.window_empty) |-> (out_ch.pooled_value == SMIN))
    else $error("empty window with a value");

  // every emitted result is registered and presented on the output
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !cmd.accept) |=> out_ch.valid)
    else $error("emitted result not presented");

endmodule

@@ sim/tb_max_pool_2d_argmax.sv @@
module tb_max_pool_2d_argmax;

  localparam int LINE_W     = 256;
  localparam int LINE_ROWS  = 8;
  localparam int WIN_LIMIT  = 256;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_CAP  = 3000000;

  typedef enum logic [1:0] {
    MODE_SEND_SLOW,
    MODE_RECV_SLOW,
    MODE_NO_IDLE
  } idle_mode_t;

  typedef struct packed {
    logic [15:0] value;
    logic [15:0] pos;
    logic        empty;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        last;
    logic        done;
  } pool_res_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic [15:0] px;
    bit          typed;
    pool_res_t   res;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [mpa_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  mpa_in_if  #(.SAMPLE_BITS(16)) in_ch ();
  mpa_out_if #(.SAMPLE_BITS(16)) out_ch ();

  max_pool_2d_argmax dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // mirror of the block's registers and line buffer
  logic [8:0] m_width, m_height;
  logic [3:0] m_win, m_step, m_pad;
  logic       m_record;
  logic signed [15:0] line_buf [LINE_ROWS][LINE_W];
  int pix_row, pix_col;

  pool_res_t  pending_pools[$];
  idle_mode_t idle_mode;
  directed_row_t directed[$];
  int errors, results_seen, pixels_sent, cfg_writes, empty_seen, capped_pixels;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout at %0t with %0d results outstanding", $time, pending_pools.size());
      $display("max_pool_2d_argmax regression: fail");
      $finish;
    end
  end

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // windows along one dimension
  function automatic int window_total(int len, int pad, int sz, int stp);
    int diff, n;
    diff = len + pad - sz;
    if (diff >= 0) n = diff / stp + 1;
    else n = (-diff < stp) ? 1 : 0;
    return n > WIN_LIMIT ? WIN_LIMIT : n;
  endfunction

  // store one pixel and queue the windows it closes, up to the result cap
  task automatic pool_pixel(input logic [15:0] px);
    int w, h, s, t, p, off, r, c, nr, nc, n, i, j, r0, c0, dr, dc, rr, cc;
    int best, pos;
    bit found;
    int ilist[$], jlist[$];
    pool_res_t batch[$];
    pool_res_t res;
    w = clamp_int(int'(m_width), 1, LINE_W);
    h = clamp_int(int'(m_height), 1, LINE_W);
    s = clamp_int(int'(m_win), 1, LINE_ROWS);
    t = (m_step == 0) ? 1 : int'(m_step);
    p = int'(m_pad);
    off = -(p / 2);
    if (pix_col >= w) pix_col = 0;
    if (pix_row >= h) pix_row = 0;
    r = pix_row;
    c = pix_col;
    line_buf[r % LINE_ROWS][c] = signed'(px);
    nr = window_total(h, p, s, t);
    nc = window_total(w, p, s, t);
    for (int k = 0; k < nr; k++)
      if (clamp_int(k * t + off + s - 1, 0, h - 1) == r) ilist.push_back(k);
    for (int k = 0; k < nc; k++)
      if (clamp_int(k * t + off + s - 1, 0, w - 1) == c) jlist.push_back(k);
    n = 0;
    foreach (ilist[a]) begin
      foreach (jlist[b]) begin
        if (n < mpa_pkg::MAX_RESULTS) begin
          i = ilist[a];
          j = jlist[b];
          r0 = i * t + off;
          c0 = j * t + off;
          best = -32768;
          pos = 0;
          found = 1'b0;
          for (dr = 0; dr < s; dr++) begin
            rr = r0 + dr;
            if (rr >= 0 && rr < h) begin
              for (dc = 0; dc < s; dc++) begin
                cc = c0 + dc;
                if (cc >= 0 && cc < w) begin
                  if (!found || int'(line_buf[rr % LINE_ROWS][cc]) > best) begin
                    best = int'(line_buf[rr % LINE_ROWS][cc]);
                    pos = rr * w + cc;
                    found = 1'b1;
                  end
                end
              end
            end
          end
          if (!m_record) pos = 0;
          else if (!found) pos = 16'hFFFF;
          res.value = best[15:0];
          res.pos   = pos[15:0];
          res.empty = !found;
          res.row   = i[7:0];
          res.col   = j[7:0];
          res.last  = 1'b0;
          res.done  = (i == nr - 1 && j == nc - 1);
          batch.push_back(res);
          n++;
        end
      end
    end
    if (ilist.size() * jlist.size() > mpa_pkg::MAX_RESULTS) capped_pixels++;
    if (n > 0) batch[n-1].last = 1'b1;
    foreach (batch[q]) pending_pools.push_back(batch[q]);
    pix_col++;
    if (pix_col >= w) begin
      pix_col = 0;
      pix_row++;
      if (pix_row >= h) pix_row = 0;
    end
  endtask

  // offer one request and hold it until accepted
  task automatic send_pixel(input logic [15:0] px);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pool_pixel(px);
    pixels_sent++;
    idle_mode = pixels_sent < 45 ? MODE_SEND_SLOW :
                (pixels_sent < 90 ? MODE_RECV_SLOW : MODE_NO_IDLE);
    if ((idle_mode == MODE_SEND_SLOW && $urandom_range(99) < 28) ||
        (idle_mode == MODE_RECV_SLOW && $urandom_range(99) < 53)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // write one register once all results have drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= mpa_pkg::CFG_ADDR_W'(idx) << 2;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      mpa_pkg::REG_IN_WIDTH:    m_width  = val[8:0];
      mpa_pkg::REG_IN_HEIGHT:   m_height = val[8:0];
      mpa_pkg::REG_WINDOW_SIZE: m_win    = val[3:0];
      mpa_pkg::REG_STEP:        m_step   = val[3:0];
      mpa_pkg::REG_PAD_TOTAL:   m_pad    = val[3:0];
      mpa_pkg::REG_RECORD:      m_record = val[0];
      default: ;
    endcase
    pix_row = 0;
    pix_col = 0;
    cfg_writes++;
  endtask

  task automatic write_all(input logic [8:0] w, input logic [8:0] h, input logic [3:0] s,
                           input logic [3:0] t, input logic [3:0] p, input logic rec);
    write_reg(mpa_pkg::REG_IN_WIDTH, 32'(w));
    write_reg(mpa_pkg::REG_IN_HEIGHT, 32'(h));
    write_reg(mpa_pkg::REG_WINDOW_SIZE, 32'(s));
    write_reg(mpa_pkg::REG_STEP, 32'(t));
    write_reg(mpa_pkg::REG_PAD_TOTAL, 32'(p));
    write_reg(mpa_pkg::REG_RECORD, 32'(rec));
  endtask

  function automatic void add_row(bit is_cfg, logic [2:0] idx, logic [31:0] val,
                                  logic [15:0] px, bit typed, pool_res_t res);
    directed_row_t d;
    d.is_cfg  = is_cfg;
    d.reg_idx = idx;
    d.reg_val = val;
    d.px      = px;
    d.typed   = typed;
    d.res     = res;
    directed.push_back(d);
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    case (idle_mode)
      MODE_SEND_SLOW: out_ch.ready <= ($urandom_range(99) >= 53);
      MODE_RECV_SLOW: out_ch.ready <= ($urandom_range(99) >= 28);
      default:        out_ch.ready <= 1'b1;
    endcase
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    pool_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.pooled_value, out_ch.max_position, out_ch.window_empty,
              out_ch.out_row, out_ch.out_col, out_ch.last_of_run, out_ch.plane_done};
      results_seen++;
      if (got.empty) empty_seen++;
      if (pending_pools.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = pending_pools.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  initial begin
    pool_res_t none;
    int w_eff, h_eff, n;
    none = '0;
    errors = 0; results_seen = 0; pixels_sent = 0; cfg_writes = 0;
    empty_seen = 0; capped_pixels = 0;
    idle_mode = MODE_SEND_SLOW;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    m_width = mpa_pkg::RST_IN_WIDTH; m_height = mpa_pkg::RST_IN_HEIGHT;
    m_win = mpa_pkg::RST_WINDOW_SIZE; m_step = mpa_pkg::RST_STEP;
    m_pad = mpa_pkg::RST_PAD_TOTAL; m_record = mpa_pkg::RST_RECORD;
    pix_row = 0; pix_col = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single pixel planes, extremes, inference mode, capped and empty windows
    add_row(1, mpa_pkg::REG_IN_WIDTH, 1, 0, 0, none);
    add_row(1, mpa_pkg::REG_IN_HEIGHT, 1, 0, 0, none);
    add_row(1, mpa_pkg::REG_WINDOW_SIZE, 1, 0, 0, none);
    add_row(1, mpa_pkg::REG_STEP, 1, 0, 0, none);
    add_row(0, 0, 0, 16'h7FFF, 1, '{16'h7FFF, 16'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1});
    add_row(0, 0, 0, 16'h8000, 1, '{16'h8000, 16'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1});
    add_row(1, mpa_pkg::REG_RECORD, 0, 0, 0, none);
    add_row(0, 0, 0, 16'h1234, 1, '{16'h1234, 16'd0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1});
    add_row(1, mpa_pkg::REG_RECORD, 1, 0, 0, none);
    add_row(1, mpa_pkg::REG_PAD_TOTAL, 4, 0, 0, none);
    add_row(0, 0, 0, 16'hFF00, 0, none);
    add_row(1, mpa_pkg::REG_PAD_TOTAL, 15, 0, 0, none);
    add_row(0, 0, 0, 16'h0100, 0, none);
    add_row(1, mpa_pkg::REG_WINDOW_SIZE, 0, 0, 0, none);
    add_row(1, mpa_pkg::REG_STEP, 0, 0, 0, none);
    add_row(0, 0, 0, 16'h00FF, 0, none);
    add_row(1, mpa_pkg::REG_IN_WIDTH, 2, 0, 0, none);
    add_row(1, mpa_pkg::REG_IN_HEIGHT, 2, 0, 0, none);
    add_row(1, mpa_pkg::REG_WINDOW_SIZE, 15, 0, 0, none);
    add_row(1, mpa_pkg::REG_STEP, 15, 0, 0, none);
    add_row(1, mpa_pkg::REG_PAD_TOTAL, 0, 0, 0, none);
    add_row(0, 0, 0, 16'h0003, 0, none);
    add_row(0, 0, 0, 16'hFFFE, 0, none);
    add_row(0, 0, 0, 16'h0003, 0, none);
    add_row(0, 0, 0, 16'h8001, 0, none);

    foreach (directed[k]) begin
      if (directed[k].is_cfg) begin
        write_reg(directed[k].reg_idx, directed[k].reg_val);
      end else begin
        send_pixel(directed[k].px);
        if (directed[k].typed) begin
          void'(pending_pools.pop_back());
          pending_pools.push_back(directed[k].res);
        end
      end
    end

    // widest row with the largest window and stride, then the reset setting
    write_all(9'h1FF, 9'd0, 4'hF, 4'hF, 4'd14, 1'b1);
    repeat (40) send_pixel(16'($urandom()));
    write_all(9'd8, 9'd8, 4'd2, 4'd2, 4'd0, 1'b1);
    repeat (64) send_pixel(16'($urandom()));

    // random settings, each with a whole plane of random pixels or, at times, a part of one
    while (pixels_sent < 130) begin
      w_eff = $urandom_range(6, 1);
      h_eff = $urandom_range(6, 1);
      write_all(9'(w_eff), 9'(h_eff), 4'($urandom_range(15)), 4'($urandom_range(15)),
                4'($urandom_range(15)), 1'($urandom_range(3) != 0));
      n = w_eff * h_eff;
      if ($urandom_range(3) == 0) n = $urandom_range(n, 1);
      repeat (n) send_pixel(16'($urandom()));
    end
    in_ch.valid <= 1'b0;

    while (pending_pools.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_pools.size() != 0) errors++;

    $display("sent %0d pixels over %0d register writes, checked %0d pooled results",
             pixels_sent, cfg_writes, results_seen);
    $display("empty windows %0d, pixels hitting the result cap %0d, errors %0d",
             empty_seen, capped_pixels, errors);
    if (errors == 0) begin
      $display("max_pool_2d_argmax regression: pass");
    end else begin
      $display("max_pool_2d_argmax regression: fail");
    end
    $finish;
  end

endmodule

@@ max_pool_2d_argmax.f @@
rtl/mpa_pkg.sv
rtl/mpa_if.sv
rtl/mpa_cfg.sv
rtl/mpa_ctrl.sv
rtl/mpa_dp.sv
rtl/max_pool_2d_argmax.sv
sim/tb_max_pool_2d_argmax.sv
